// File: rtl/core/simple_8bit_machine_execute_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the simple 8-bit machine execute core.
// Each macro checks a property on the rising edge of clk, outside reset.
// ----------------------------------------------------------------------------
`ifndef SIMPLE_8BIT_MACHINE_EXECUTE_CORE_ASSERT_SVH
`define SIMPLE_8BIT_MACHINE_EXECUTE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define S8ME_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s8me: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define S8ME_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s8me: next-cycle check failed");

`else

`define S8ME_ASSERT_IMP(label, ante, cons)
`define S8ME_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: rtl/core/s8me_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s8me_pkg
// Shared types, codes and the microcode program of the execute core.
// ----------------------------------------------------------------------------
package s8me_pkg;

  localparam int unsigned UPC_W = 5;
  localparam int unsigned RF_AW = 4;

  // Item operations.
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_EXEC    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMIT    = 2'd1;
  localparam logic [1:0] ST_HALT    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Instruction opcodes.
  localparam logic [3:0] OPC_LOAD  = 4'h1;
  localparam logic [3:0] OPC_IMM   = 4'h2;
  localparam logic [3:0] OPC_STORE = 4'h3;
  localparam logic [3:0] OPC_MOVE  = 4'h4;
  localparam logic [3:0] OPC_ADD   = 4'h5;
  localparam logic [3:0] OPC_JUMP  = 4'hB;
  localparam logic [3:0] OPC_HALT  = 4'hC;

  // Memory address select.
  localparam logic [2:0] MA_PC     = 3'd0;
  localparam logic [2:0] MA_PC1    = 3'd1;
  localparam logic [2:0] MA_LO_RAW = 3'd2;
  localparam logic [2:0] MA_LO     = 3'd3;
  localparam logic [2:0] MA_IN     = 3'd4;

  // Memory write data select.
  localparam logic MW_IN = 1'b0;
  localparam logic MW_RA = 1'b1;

  // Register file read address selects.
  localparam logic RA_R  = 1'b0;
  localparam logic RA_X  = 1'b1;
  localparam logic RB_R0 = 1'b0;
  localparam logic RB_Y  = 1'b1;

  // Register file write address and data selects.
  localparam logic       WA_R   = 1'b0;
  localparam logic       WA_Y   = 1'b1;
  localparam logic [1:0] WD_MEM = 2'd0;
  localparam logic [1:0] WD_LO  = 2'd1;
  localparam logic [1:0] WD_RA  = 2'd2;
  localparam logic [1:0] WD_SUM = 2'd3;

  // Program counter update.
  localparam logic [1:0] PC_HOLD = 2'd0;
  localparam logic [1:0] PC_INC2 = 2'd1;
  localparam logic [1:0] PC_ZERO = 2'd2;
  localparam logic [1:0] PC_JEQ  = 2'd3;

  // Halt flag update.
  localparam logic [1:0] HF_NONE = 2'd0;
  localparam logic [1:0] HF_SET  = 2'd1;
  localparam logic [1:0] HF_CLR  = 2'd2;

  // Sequencing.
  localparam logic [1:0] SEQ_NEXT     = 2'd0;
  localparam logic [1:0] SEQ_DISPATCH = 2'd1;
  localparam logic [1:0] SEQ_COND     = 2'd2;
  localparam logic [1:0] SEQ_DONE     = 2'd3;

  // Branch conditions.
  localparam logic [1:0] CC_NONE      = 2'd0;
  localparam logic [1:0] CC_STORE_OUT = 2'd1;
  localparam logic [1:0] CC_R_NZ      = 2'd2;
  localparam logic [1:0] CC_HALT_BAD  = 2'd3;

  // Microcode addresses.
  localparam logic [UPC_W-1:0] U_WRMEM     = 5'd0;
  localparam logic [UPC_W-1:0] U_RESTART   = 5'd1;
  localparam logic [UPC_W-1:0] U_OPNOP     = 5'd2;
  localparam logic [UPC_W-1:0] U_HALTED    = 5'd3;
  localparam logic [UPC_W-1:0] U_FETCH_HI  = 5'd4;
  localparam logic [UPC_W-1:0] U_FETCH_LO  = 5'd5;
  localparam logic [UPC_W-1:0] U_D_LOAD    = 5'd6;
  localparam logic [UPC_W-1:0] U_E_LOAD    = 5'd7;
  localparam logic [UPC_W-1:0] U_D_IMM     = 5'd8;
  localparam logic [UPC_W-1:0] U_E_IMM     = 5'd9;
  localparam logic [UPC_W-1:0] U_D_STORE   = 5'd10;
  localparam logic [UPC_W-1:0] U_E_STORE   = 5'd11;
  localparam logic [UPC_W-1:0] U_D_MOVE    = 5'd12;
  localparam logic [UPC_W-1:0] U_E_MOVE    = 5'd13;
  localparam logic [UPC_W-1:0] U_D_ADD     = 5'd14;
  localparam logic [UPC_W-1:0] U_E_ADD     = 5'd15;
  localparam logic [UPC_W-1:0] U_D_JUMP    = 5'd16;
  localparam logic [UPC_W-1:0] U_E_JUMP    = 5'd17;
  localparam logic [UPC_W-1:0] U_D_HALT    = 5'd18;
  localparam logic [UPC_W-1:0] U_E_HALT    = 5'd19;
  localparam logic [UPC_W-1:0] U_D_NOP     = 5'd20;
  localparam logic [UPC_W-1:0] U_E_NOP     = 5'd21;
  localparam logic [UPC_W-1:0] U_E_EMIT    = 5'd22;
  localparam logic [UPC_W-1:0] U_E_INVALID = 5'd23;

  typedef struct packed {
    logic             mem_rd;
    logic             mem_wr;
    logic [2:0]       maddr_sel;
    logic             mwdata_sel;
    logic             ld_hi;
    logic             ld_lo;
    logic             rf_rd;
    logic             ra_sel;
    logic             rb_sel;
    logic             rf_we;
    logic             wa_sel;
    logic [1:0]       wd_sel;
    logic [1:0]       pc_op;
    logic [1:0]       halt_op;
    logic [1:0]       status;
    logic             emit;
    logic [1:0]       seq;
    logic [1:0]       cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic       halted;
    logic       halted_nxt;
    logic [7:0] pc_nxt;
    logic [3:0] opcode;
    logic       c_store_out;
    logic       c_r_nz;
    logic       c_halt_bad;
    logic [7:0] emit_value;
  } dp_stat_t;

  // Entry point of the program for an accepted item.
  function automatic logic [UPC_W-1:0] entry_addr(input logic [1:0] op, input logic halted);
    logic [UPC_W-1:0] a;
    begin
      unique case (op)
        OP_WRITE:   a = U_WRMEM;
        OP_EXEC:    a = halted ? U_HALTED : U_FETCH_HI;
        OP_RESTART: a = U_RESTART;
        default:    a = U_OPNOP;
      endcase
      return a;
    end
  endfunction

  // Decode step chosen by the opcode of the fetched high byte.
  function automatic logic [UPC_W-1:0] opcode_addr(input logic [3:0] opc);
    logic [UPC_W-1:0] a;
    begin
      unique case (opc)
        OPC_LOAD:  a = U_D_LOAD;
        OPC_IMM:   a = U_D_IMM;
        OPC_STORE: a = U_D_STORE;
        OPC_MOVE:  a = U_D_MOVE;
        OPC_ADD:   a = U_D_ADD;
        OPC_JUMP:  a = U_D_JUMP;
        OPC_HALT:  a = U_D_HALT;
        default:   a = U_D_NOP;
      endcase
      return a;
    end
  endfunction

  // The microcode program.
  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] a);
    ctrl_t w;
    begin
      w        = '0;
      w.seq    = SEQ_DONE;
      w.status = ST_OK;
      unique case (a)
        U_WRMEM: begin
          w.mem_wr     = 1'b1;
          w.maddr_sel  = MA_IN;
          w.mwdata_sel = MW_IN;
        end
        U_RESTART: begin
          w.pc_op   = PC_ZERO;
          w.halt_op = HF_CLR;
        end
        U_OPNOP: begin
          w.status = ST_OK;
        end
        U_HALTED: begin
          w.status = ST_HALT;
        end
        U_FETCH_HI: begin
          w.mem_rd    = 1'b1;
          w.maddr_sel = MA_PC;
          w.seq       = SEQ_NEXT;
        end
        U_FETCH_LO: begin
          w.ld_hi     = 1'b1;
          w.mem_rd    = 1'b1;
          w.maddr_sel = MA_PC1;
          w.seq       = SEQ_DISPATCH;
        end
        U_D_LOAD: begin
          w.ld_lo     = 1'b1;
          w.mem_rd    = 1'b1;
          w.maddr_sel = MA_LO_RAW;
          w.seq       = SEQ_NEXT;
        end
        U_E_LOAD: begin
          w.rf_we  = 1'b1;
          w.wa_sel = WA_R;
          w.wd_sel = WD_MEM;
          w.pc_op  = PC_INC2;
        end
        U_D_IMM: begin
          w.ld_lo = 1'b1;
          w.seq   = SEQ_NEXT;
        end
        U_E_IMM: begin
          w.rf_we  = 1'b1;
          w.wa_sel = WA_R;
          w.wd_sel = WD_LO;
          w.pc_op  = PC_INC2;
        end
        U_D_STORE: begin
          w.ld_lo  = 1'b1;
          w.rf_rd  = 1'b1;
          w.ra_sel = RA_R;
          w.seq    = SEQ_COND;
          w.cond   = CC_STORE_OUT;
          w.target = U_E_EMIT;
        end
        U_E_STORE: begin
          w.mem_wr     = 1'b1;
          w.maddr_sel  = MA_LO;
          w.mwdata_sel = MW_RA;
          w.pc_op      = PC_INC2;
        end
        U_D_MOVE: begin
          w.ld_lo  = 1'b1;
          w.rf_rd  = 1'b1;
          w.ra_sel = RA_X;
          w.seq    = SEQ_COND;
          w.cond   = CC_R_NZ;
          w.target = U_E_INVALID;
        end
        U_E_MOVE: begin
          w.rf_we  = 1'b1;
          w.wa_sel = WA_Y;
          w.wd_sel = WD_RA;
          w.pc_op  = PC_INC2;
        end
        U_D_ADD: begin
          w.ld_lo  = 1'b1;
          w.rf_rd  = 1'b1;
          w.ra_sel = RA_X;
          w.rb_sel = RB_Y;
          w.seq    = SEQ_NEXT;
        end
        U_E_ADD: begin
          w.rf_we  = 1'b1;
          w.wa_sel = WA_R;
          w.wd_sel = WD_SUM;
          w.pc_op  = PC_INC2;
        end
        U_D_JUMP: begin
          w.ld_lo  = 1'b1;
          w.rf_rd  = 1'b1;
          w.ra_sel = RA_R;
          w.rb_sel = RB_R0;
          w.seq    = SEQ_NEXT;
        end
        U_E_JUMP: begin
          w.pc_op = PC_JEQ;
        end
        U_D_HALT: begin
          w.ld_lo  = 1'b1;
          w.seq    = SEQ_COND;
          w.cond   = CC_HALT_BAD;
          w.target = U_E_INVALID;
        end
        U_E_HALT: begin
          w.halt_op = HF_SET;
          w.status  = ST_HALT;
        end
        U_D_NOP: begin
          w.ld_lo = 1'b1;
          w.seq   = SEQ_NEXT;
        end
        U_E_NOP: begin
          w.pc_op = PC_INC2;
        end
        U_E_EMIT: begin
          w.emit   = 1'b1;
          w.status = ST_EMIT;
          w.pc_op  = PC_INC2;
        end
        U_E_INVALID: begin
          w.status = ST_INVALID;
          w.pc_op  = PC_INC2;
        end
        default: begin
          w.status = ST_OK;
        end
      endcase
      return w;
    end
  endfunction

endpackage

// File: rtl/core/s8me_useq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s8me_useq
// Microcode sequencer: step counter, program table and item handshake.
// ----------------------------------------------------------------------------
module s8me_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  input  logic               out_block,
  input  s8me_pkg::dp_stat_t stat,
  output logic               in_ready,
  output logic               in_fire,
  output logic               done_fire,
  output s8me_pkg::ctrl_t    ctrl
);

  logic                         busy_r;
  logic                         busy_nxt;
  logic [s8me_pkg::UPC_W-1:0]   upc_r;
  logic [s8me_pkg::UPC_W-1:0]   upc_nxt;
  logic [s8me_pkg::UPC_W-1:0]   upc_inc;
  s8me_pkg::ctrl_t              word;
  logic                         is_done;
  logic                         step;
  logic                         cond_hit;

  assign word    = s8me_pkg::ucode_rom(upc_r);
  assign is_done = busy_r && (word.seq == s8me_pkg::SEQ_DONE);
  // The final step of an item waits while the output register is still full.
  assign step      = busy_r && !(is_done && out_block);
  assign done_fire = is_done && !out_block;
  assign in_ready  = !busy_r || done_fire;
  assign in_fire   = in_valid && in_ready;
  assign ctrl      = step ? word : '0;
  assign upc_inc   = s8me_pkg::UPC_W'(upc_r + 1'b1);

  always_comb begin
    case (word.cond)
      s8me_pkg::CC_STORE_OUT: cond_hit = stat.c_store_out;
      s8me_pkg::CC_R_NZ:      cond_hit = stat.c_r_nz;
      s8me_pkg::CC_HALT_BAD:  cond_hit = stat.c_halt_bad;
      default:                cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      upc_nxt  = s8me_pkg::entry_addr(in_op, stat.halted_nxt);
    end else if (done_fire) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      unique case (word.seq)
        s8me_pkg::SEQ_NEXT:     upc_nxt = upc_inc;
        s8me_pkg::SEQ_DISPATCH: upc_nxt = s8me_pkg::opcode_addr(stat.opcode);
        s8me_pkg::SEQ_COND:     upc_nxt = cond_hit ? word.target : upc_inc;
        default:                upc_nxt = upc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= s8me_pkg::U_OPNOP;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
    end
  end

endmodule

// File: rtl/core/s8me_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s8me_datapath
// Memory, register file, instruction register, program counter and halt flag.
// ----------------------------------------------------------------------------
module s8me_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  s8me_pkg::ctrl_t    ctrl,
  input  logic               in_fire,
  input  logic [7:0]         in_address,
  input  logic [7:0]         in_data,
  input  logic               port_en,
  output s8me_pkg::dp_stat_t stat
);

  // Main memory with one port; a cleared valid bit makes an entry read as zero.
  logic [7:0]   mem_r [256];
  logic [255:0] mem_vld_r;
  logic [7:0]   mem_q_r;
  logic         mem_qv_r;
  logic [7:0]   mem_rdata;
  logic [7:0]   maddr;
  logic [7:0]   mwdata;

  // Register file: two read ports, one write port.
  logic [7:0]                 rf_r [16];
  logic [15:0]                rf_vld_r;
  logic [7:0]                 ra_q_r;
  logic [7:0]                 rb_q_r;
  logic [s8me_pkg::RF_AW-1:0] ra_addr;
  logic [s8me_pkg::RF_AW-1:0] rb_addr;
  logic [s8me_pkg::RF_AW-1:0] wa_addr;
  logic [7:0]                 rf_wdata;

  logic [7:0] pc_r;
  logic [7:0] pc_nxt;
  logic [7:0] pc_inc2;
  logic       halted_r;
  logic       halted_nxt;
  logic [7:0] ir_hi_r;
  logic [7:0] ir_lo_r;
  logic [7:0] in_addr_r;
  logic [7:0] in_data_r;

  assign mem_rdata = mem_qv_r ? mem_q_r : 8'd0;
  assign pc_inc2   = 8'(pc_r + 8'd2);

  always_comb begin
    case (ctrl.maddr_sel)
      s8me_pkg::MA_PC:     maddr = pc_r;
      s8me_pkg::MA_PC1:    maddr = 8'(pc_r + 8'd1);
      s8me_pkg::MA_LO_RAW: maddr = mem_rdata;
      s8me_pkg::MA_LO:     maddr = ir_lo_r;
      s8me_pkg::MA_IN:     maddr = in_addr_r;
      default:             maddr = pc_r;
    endcase
  end

  assign mwdata  = (ctrl.mwdata_sel == s8me_pkg::MW_IN) ? in_data_r : ra_q_r;
  assign ra_addr = (ctrl.ra_sel == s8me_pkg::RA_R) ? ir_hi_r[3:0] : mem_rdata[7:4];
  assign rb_addr = (ctrl.rb_sel == s8me_pkg::RB_R0) ? 4'd0 : mem_rdata[3:0];
  assign wa_addr = (ctrl.wa_sel == s8me_pkg::WA_R) ? ir_hi_r[3:0] : ir_lo_r[3:0];

  always_comb begin
    case (ctrl.wd_sel)
      s8me_pkg::WD_MEM: rf_wdata = mem_rdata;
      s8me_pkg::WD_LO:  rf_wdata = ir_lo_r;
      s8me_pkg::WD_RA:  rf_wdata = ra_q_r;
      default:          rf_wdata = 8'(ra_q_r + rb_q_r);
    endcase
  end

  always_comb begin
    case (ctrl.pc_op)
      s8me_pkg::PC_HOLD: pc_nxt = pc_r;
      s8me_pkg::PC_INC2: pc_nxt = pc_inc2;
      s8me_pkg::PC_ZERO: pc_nxt = 8'd0;
      default:           pc_nxt = (ra_q_r == rb_q_r) ? ir_lo_r : pc_inc2;
    endcase
  end

  always_comb begin
    case (ctrl.halt_op)
      s8me_pkg::HF_SET: halted_nxt = 1'b1;
      s8me_pkg::HF_CLR: halted_nxt = 1'b0;
      default:          halted_nxt = halted_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_wr) begin
      mem_r[maddr] <= mwdata;
    end
    if (ctrl.mem_rd) begin
      mem_q_r <= mem_r[maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
      mem_qv_r  <= 1'b0;
    end else begin
      if (ctrl.mem_wr) begin
        mem_vld_r[maddr] <= 1'b1;
      end
      if (ctrl.mem_rd) begin
        mem_qv_r <= mem_vld_r[maddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rf_we) begin
      rf_r[wa_addr] <= rf_wdata;
    end
  end

  // Read data is zeroed here when the entry was never written since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else begin
      if (ctrl.rf_we) begin
        rf_vld_r[wa_addr] <= 1'b1;
      end
      if (ctrl.rf_rd) begin
        ra_q_r <= rf_vld_r[ra_addr] ? rf_r[ra_addr] : 8'd0;
        rb_q_r <= rf_vld_r[rb_addr] ? rf_r[rb_addr] : 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= 8'd0;
      halted_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_hi) begin
      ir_hi_r <= mem_rdata;
    end
    if (ctrl.ld_lo) begin
      ir_lo_r <= mem_rdata;
    end
    if (in_fire) begin
      in_addr_r <= in_address;
      in_data_r <= in_data;
    end
  end

  always_comb begin
    stat.halted      = halted_r;
    stat.halted_nxt  = halted_nxt;
    stat.pc_nxt      = pc_nxt;
    stat.opcode      = mem_rdata[7:4];
    stat.c_store_out = (mem_rdata == 8'd0) && port_en;
    stat.c_r_nz      = (ir_hi_r[3:0] != 4'd0);
    stat.c_halt_bad  = (ir_hi_r[3:0] != 4'd0) || (mem_rdata != 8'd0);
    stat.emit_value  = ctrl.emit ? ra_q_r : 8'd0;
  end

endmodule

// File: rtl/core/simple_8bit_machine_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_8bit_machine_execute_core
// Teaching machine with 256-byte memory and sixteen registers, one word per item.
// ----------------------------------------------------------------------------
// Usage: each input word is a memory byte write, the execution of one 16-bit
// instruction at the program counter, a restart at address zero, or a no-op
// for op code 3. Every input word yields exactly one result word with a
// status, an emitted value and the program counter after the item. The
// output_port_enable register is written through the cfg channel, which is
// always ready; write it only while no item is in flight. Synchronous reset
// clears memory, registers, program counter and the halt flag, and sets
// output_port_enable to one. An executed instruction runs a high-byte fetch,
// a low-byte fetch that dispatches on the opcode, a decode step and an
// execute step; any other item finishes in its entry step. The result is
// registered into the output register at the end of the last step. A new
// input word is accepted in the same cycle as the last step of the previous
// item, so items run back to back while the receiver keeps up. When the
// receiver stalls, the result waits in the output register and the next
// item holds at its final step until the register is free.
// ----------------------------------------------------------------------------
`include "simple_8bit_machine_execute_core_assert.svh"

module simple_8bit_machine_execute_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_address,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_out_value,
  output logic [7:0] out_program_counter,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  s8me_pkg::ctrl_t    ctrl;
  s8me_pkg::dp_stat_t dp_stat;
  logic               in_fire;
  logic               done_fire;
  logic               out_block;

  // Configuration and output registers.
  logic       cfg_en_r;
  logic       out_valid_r;
  logic [1:0] out_status_r;
  logic [7:0] out_value_r;
  logic [7:0] out_pc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r <= 1'b1;
    end else if (cfg_valid) begin
      cfg_en_r <= cfg_data;
    end
  end

  // The final step of an item may not overwrite a result that is still waiting.
  assign out_block = out_valid_r && !out_ready;

  s8me_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .out_block (out_block),
    .stat      (dp_stat),
    .in_ready  (in_ready),
    .in_fire   (in_fire),
    .done_fire (done_fire),
    .ctrl      (ctrl)
  );

  s8me_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_fire    (in_fire),
    .in_address (in_address),
    .in_data    (in_data),
    .port_en    (cfg_en_r),
    .stat       (dp_stat)
  );

  // The result is taken from the last control word and the program counter
  // value that the same step writes back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_status_r <= ctrl.status;
      out_value_r  <= dp_stat.emit_value;
      out_pc_r     <= dp_stat.pc_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_out_value       = out_value_r;
  assign out_program_counter = out_pc_r;

  // A finished item always leaves a result in the output register.
  `S8ME_ASSERT_NXT(a_done_gives_result, done_fire, out_valid_r)
  // Only an emitting store carries a nonzero value.
  `S8ME_ASSERT_IMP(a_value_only_on_emit, out_valid_r && (out_status_r != s8me_pkg::ST_EMIT), out_value_r == 8'd0)
  // A halted result leaves the machine halted until the next item completes.
  `S8ME_ASSERT_IMP(a_halt_status_flag, out_valid_r && (out_status_r == s8me_pkg::ST_HALT), dp_stat.halted)

endmodule
